@@ rtl/cpu8_rfe_pkg.sv @@
`default_nettype none

package cpu8_rfe_pkg;

  localparam int DATA_W = 8;
  localparam int MODE_W = 5;

  // Bit positions in the status byte.
  localparam int FLAG_N = 7;
  localparam int FLAG_V = 6;
  localparam int FLAG_D = 3;
  localparam int FLAG_I = 2;
  localparam int FLAG_Z = 1;
  localparam int FLAG_C = 0;

  // Bits 5 and 4 of the status byte always read zero.
  localparam logic [DATA_W-1:0] FLAG_MASK    = 8'hCF;
  localparam logic [DATA_W-1:0] STATUS_RESET = 8'h04;

  typedef logic [DATA_W-1:0] byte_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_ORA = 5'd0,
    MODE_AND = 5'd1,
    MODE_EOR = 5'd2,
    MODE_ADC = 5'd3,
    MODE_BIT = 5'd4,
    MODE_LDA = 5'd5,
    MODE_LDX = 5'd6,
    MODE_LDY = 5'd7,
    MODE_STA = 5'd8,
    MODE_STX = 5'd9,
    MODE_STY = 5'd10,
    MODE_ASL = 5'd11,
    MODE_LSR = 5'd12,
    MODE_ROL = 5'd13,
    MODE_ROR = 5'd14,
    MODE_TXA = 5'd15,
    MODE_TAX = 5'd16,
    MODE_TYA = 5'd17,
    MODE_TAY = 5'd18,
    MODE_DEY = 5'd19,
    MODE_CLC = 5'd20,
    MODE_SEC = 5'd21,
    MODE_CLI = 5'd22,
    MODE_SEI = 5'd23,
    MODE_CLD = 5'd24,
    MODE_BPL = 5'd25,
    MODE_BMI = 5'd26,
    MODE_BVC = 5'd27,
    MODE_BVS = 5'd28,
    MODE_BCC = 5'd29,
    MODE_BCS = 5'd30
  } mode_t;

  // Architectural register file.
  typedef struct packed {
    byte_t acc;
    byte_t xreg;
    byte_t yreg;
    byte_t status;
  } regs_t;

  // Everything one operation produces.
  typedef struct packed {
    logic  write_enable;
    byte_t write_data;
    logic  branch_taken;
    regs_t regs;
  } exec_t;

endpackage

`default_nettype wire

@@ rtl/cpu8_rfe_in_if.sv @@
`default_nettype none

interface cpu8_rfe_in_if;
  logic       valid;
  logic       ready;
  logic [4:0] mode;
  logic [7:0] operand_value;
  logic       on_accumulator;

  modport source (output valid, output mode, output operand_value, output on_accumulator,
                  input ready);
  modport sink (input valid, input mode, input operand_value, input on_accumulator,
                output ready);
endinterface

`default_nettype wire

@@ rtl/cpu8_rfe_out_if.sv @@
`default_nettype none

interface cpu8_rfe_out_if;
  logic       valid;
  logic       ready;
  logic       write_enable;
  logic [7:0] write_data;
  logic       branch_taken;
  logic [7:0] acc_out;
  logic [7:0] xreg_out;
  logic [7:0] yreg_out;
  logic [7:0] status_out;

  modport source (output valid, output write_enable, output write_data, output branch_taken,
                  output acc_out, output xreg_out, output yreg_out, output status_out,
                  input ready);
  modport sink (input valid, input write_enable, input write_data, input branch_taken,
                input acc_out, input xreg_out, input yreg_out, input status_out,
                output ready);
endinterface

`default_nettype wire

@@ rtl/cpu8_register_flag_execute.sv @@
`default_nettype none

// Channel     Role   Payload
// ---------   ----   ---------------------------------------------------------------
// operation   sink   mode, operand_value, on_accumulator
// result      source write_enable, write_data, branch_taken, acc_out, xreg_out,
//                    yreg_out, status_out
//
// One word is accepted per cycle while results are taken; each word is captured in the
// input register, then the execute logic loads the result register from it. The result
// is offered from the result register until it is taken.
// Registers A, X, Y and the status byte update at the edge that loads the result.
// While the result register holds a word that is not taken, the input register fills
// and then operation.ready drops; no word is lost or repeated.
// Reset clears A, X and Y, sets status to interrupt disable, and empties both stages.

module cpu8_register_flag_execute (
  input wire logic      clk,
  input wire logic      rst,
  cpu8_rfe_in_if.sink   operation,
  cpu8_rfe_out_if.source result
);
  import cpu8_rfe_pkg::*;

  // Input stage.
  logic              s1_valid;
  logic [MODE_W-1:0] s1_mode;
  byte_t             s1_operand;
  logic              s1_on_acc;

  // Architectural state and result stage.
  regs_t regs;
  logic  out_valid;
  exec_t out_word;
  exec_t exec;
  logic  advance;

  assign advance         = s1_valid && (!out_valid || result.ready);
  assign operation.ready = !s1_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (operation.ready) begin
      s1_valid <= operation.valid;
    end
    if (operation.valid && operation.ready) begin
      s1_mode    <= operation.mode;
      s1_operand <= operation.operand_value;
      s1_on_acc  <= operation.on_accumulator;
    end
  end

  cpu8_rfe_alu u_alu (
    .mode           (s1_mode),
    .operand_value  (s1_operand),
    .on_accumulator (s1_on_acc),
    .regs           (regs),
    .exec           (exec)
  );

  // Register file update and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.acc    <= '0;
      regs.xreg   <= '0;
      regs.yreg   <= '0;
      regs.status <= STATUS_RESET;
      out_valid   <= 1'b0;
    end else if (advance) begin
      regs      <= exec.regs;
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      out_word <= exec;
    end
  end

  assign result.valid        = out_valid;
  assign result.write_enable = out_word.write_enable;
  assign result.write_data   = out_word.write_data;
  assign result.branch_taken = out_word.branch_taken;
  assign result.acc_out      = out_word.regs.acc;
  assign result.xreg_out     = out_word.regs.xreg;
  assign result.yreg_out     = out_word.regs.yreg;
  assign result.status_out   = out_word.regs.status;

  // Reset leaves the documented register state.
  a_reset_state: assert property (@(posedge clk)
    rst |=> (regs.status == STATUS_RESET) && (regs.acc == '0) && !out_valid)
    else $error("register state wrong after reset");

  // A pending result always shows the current register file.
  a_out_tracks_regs: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_word.regs == regs))
    else $error("result registers differ from register file");

  // Unused status bits stay clear.
  a_status_mask: assert property (@(posedge clk) disable iff (rst)
    (regs.status & ~FLAG_MASK) == '0)
    else $error("unused status bits set");

  // No write data without a write, and never a write with a taken branch.
  a_write_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_word.write_enable || out_word.write_data == '0)
                  && !(out_word.write_enable && out_word.branch_taken))
    else $error("inconsistent write or branch outputs");

  // Decimal mode can only be cleared, never set.
  a_no_decimal: assert property (@(posedge clk) disable iff (rst)
    !$rose(regs.status[FLAG_D]))
    else $error("decimal flag set");

endmodule

`default_nettype wire

@@ rtl/cpu8_rfe_alu.sv @@
`default_nettype none

module cpu8_rfe_alu (
  input  wire logic [cpu8_rfe_pkg::MODE_W-1:0] mode,
  input  wire cpu8_rfe_pkg::byte_t             operand_value,
  input  wire logic                            on_accumulator,
  input  wire cpu8_rfe_pkg::regs_t             regs,
  output cpu8_rfe_pkg::exec_t                  exec
);
  import cpu8_rfe_pkg::*;

  logic  carry_in;
  logic  [DATA_W:0] sum;
  byte_t adc_res;
  byte_t shift_src;
  byte_t shift_res;
  logic  shift_cout;
  byte_t nz_val;
  logic  nz_upd;
  regs_t nxt;

  assign carry_in = regs.status[FLAG_C];

  // Binary add with carry.
  assign sum     = {1'b0, regs.acc} + {1'b0, operand_value} + {{DATA_W{1'b0}}, carry_in};
  assign adc_res = sum[DATA_W-1:0];

  // Shift and rotate unit, on A or on the memory byte.
  assign shift_src = on_accumulator ? regs.acc : operand_value;

  always_comb begin
    case (mode_t'(mode))
      MODE_ASL: begin
        shift_cout = shift_src[7];
        shift_res  = {shift_src[6:0], 1'b0};
      end
      MODE_LSR: begin
        shift_cout = shift_src[0];
        shift_res  = {1'b0, shift_src[7:1]};
      end
      MODE_ROL: begin
        shift_cout = shift_src[7];
        shift_res  = {shift_src[6:0], carry_in};
      end
      default: begin
        shift_cout = shift_src[0];
        shift_res  = {carry_in, shift_src[7:1]};
      end
    endcase
  end

  // Register and flag update for the decoded operation.
  always_comb begin
    nxt                = regs;
    nz_val             = '0;
    nz_upd             = 1'b0;
    exec.write_enable  = 1'b0;
    exec.write_data    = '0;
    exec.branch_taken  = 1'b0;
    case (mode_t'(mode))
      MODE_ORA: begin
        nxt.acc = regs.acc | operand_value;
        nz_val  = nxt.acc;
        nz_upd  = 1'b1;
      end
      MODE_AND: begin
        nxt.acc = regs.acc & operand_value;
        nz_val  = nxt.acc;
        nz_upd  = 1'b1;
      end
      MODE_EOR: begin
        nxt.acc = regs.acc ^ operand_value;
        nz_val  = nxt.acc;
        nz_upd  = 1'b1;
      end
      MODE_ADC: begin
        nxt.acc            = adc_res;
        nxt.status[FLAG_V] = (regs.acc[7] ^ adc_res[7]) & (operand_value[7] ^ adc_res[7]);
        nxt.status[FLAG_C] = sum[DATA_W];
        nz_val             = adc_res;
        nz_upd             = 1'b1;
      end
      MODE_BIT: begin
        nxt.status[FLAG_N] = operand_value[7];
        nxt.status[FLAG_V] = operand_value[6];
        nxt.status[FLAG_Z] = ((operand_value & regs.acc) == '0);
      end
      MODE_LDA: begin
        nxt.acc = operand_value;
        nz_val  = operand_value;
        nz_upd  = 1'b1;
      end
      MODE_LDX: begin
        nxt.xreg = operand_value;
        nz_val   = operand_value;
        nz_upd   = 1'b1;
      end
      MODE_LDY: begin
        nxt.yreg = operand_value;
        nz_val   = operand_value;
        nz_upd   = 1'b1;
      end
      MODE_STA: begin
        exec.write_enable = 1'b1;
        exec.write_data   = regs.acc;
      end
      MODE_STX: begin
        exec.write_enable = 1'b1;
        exec.write_data   = regs.xreg;
      end
      MODE_STY: begin
        exec.write_enable = 1'b1;
        exec.write_data   = regs.yreg;
      end
      MODE_ASL, MODE_LSR, MODE_ROL, MODE_ROR: begin
        nxt.status[FLAG_C] = shift_cout;
        nz_val             = shift_res;
        nz_upd             = 1'b1;
        if (on_accumulator) begin
          nxt.acc = shift_res;
        end else begin
          exec.write_enable = 1'b1;
          exec.write_data   = shift_res;
        end
      end
      MODE_TXA: begin
        nxt.acc = regs.xreg;
        nz_val  = regs.xreg;
        nz_upd  = 1'b1;
      end
      MODE_TAX: begin
        nxt.xreg = regs.acc;
        nz_val   = regs.acc;
        nz_upd   = 1'b1;
      end
      MODE_TYA: begin
        nxt.acc = regs.yreg;
        nz_val  = regs.yreg;
        nz_upd  = 1'b1;
      end
      MODE_TAY: begin
        nxt.yreg = regs.acc;
        nz_val   = regs.acc;
        nz_upd   = 1'b1;
      end
      MODE_DEY: begin
        nxt.yreg = regs.yreg - 8'd1;
        nz_val   = nxt.yreg;
        nz_upd   = 1'b1;
      end
      MODE_CLC: nxt.status[FLAG_C] = 1'b0;
      MODE_SEC: nxt.status[FLAG_C] = 1'b1;
      MODE_CLI: nxt.status[FLAG_I] = 1'b0;
      MODE_SEI: nxt.status[FLAG_I] = 1'b1;
      MODE_CLD: nxt.status[FLAG_D] = 1'b0;
      MODE_BPL: exec.branch_taken = ~regs.status[FLAG_N];
      MODE_BMI: exec.branch_taken = regs.status[FLAG_N];
      MODE_BVC: exec.branch_taken = ~regs.status[FLAG_V];
      MODE_BVS: exec.branch_taken = regs.status[FLAG_V];
      MODE_BCC: exec.branch_taken = ~regs.status[FLAG_C];
      MODE_BCS: exec.branch_taken = regs.status[FLAG_C];
      default: begin
      end
    endcase

    // Negative and zero follow the result byte where the operation sets them.
    if (nz_upd) begin
      nxt.status[FLAG_N] = nz_val[7];
      nxt.status[FLAG_Z] = (nz_val == '0);
    end
    nxt.status = nxt.status & FLAG_MASK;
    exec.regs  = nxt;
  end

endmodule

`default_nettype wire
